// ----- rtl/sus_pkg.sv -----
// ----------------------------------------------------------------------------
// sus_pkg
// Shared types and codes for the sorted unique set builder.
// ----------------------------------------------------------------------------
`default_nettype none

package sus_pkg;

    localparam int KEY_W   = 32;
    localparam int RIDX_W  = 8;
    localparam int POS_W   = 8;
    localparam int CNT_O_W = 9;

    // request kinds carried on s_tuser
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_FIND   = 2'd1,
        REQ_READ   = 2'd2
    } req_t;

    // per-cell status seen by the neighbor and the reduction logic
    typedef struct packed {
        logic valid;
        logic lt;
        logic eq;
        logic sel;
    } cell_stat_t;

endpackage

`default_nettype wire

// ----- rtl/sus_cell.sv -----
// ----------------------------------------------------------------------------
// sus_cell
// One slot of the sorted row: holds a value, compares it with the key and
// takes the key or its left neighbor's value on an insert.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_cell
    import sus_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [RIDX_W-1:0] read_index,
    input  wire logic              ins_en,
    input  wire logic              left_lt,
    input  wire logic              left_valid,
    input  wire logic [KEY_W-1:0]  left_value,
    output logic      [KEY_W-1:0]  value,
    output cell_stat_t             stat
);

    logic [KEY_W-1:0] value_reg;
    logic [KEY_W-1:0] value_next;
    logic             valid_reg;
    logic             valid_next;
    logic             lt;

    assign lt = valid_reg && (value_reg < key);

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ins_en && !lt) begin
            // first non-smaller slot takes the key, the rest shift up
            value_next = left_lt ? key : left_value;
            valid_next = left_lt ? 1'b1 : left_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value      = value_reg;
    assign stat.valid = valid_reg;
    assign stat.lt    = lt;
    assign stat.eq    = valid_reg && (value_reg == key);
    assign stat.sel   = (CELL_INDEX < (1 << RIDX_W)) && (read_index == RIDX_W'(CELL_INDEX));

endmodule

`default_nettype wire

// ----- rtl/sus_reduce.sv -----
// ----------------------------------------------------------------------------
// sus_reduce
// Collapses the cell row status into match, insert position, full flag and
// the selected entry for a read.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_reduce
    import sus_pkg::*;
#(
    parameter int CAPACITY = 256,
    parameter int PW       = 8
) (
    input  wire cell_stat_t            stat [CAPACITY],
    input  wire logic [KEY_W-1:0]      value [CAPACITY],
    output logic                       any_eq,
    output logic                       full,
    output logic      [PW-1:0]         at_pos,
    output logic                       rd_hit,
    output logic      [KEY_W-1:0]      rd_value
);

    always_comb begin
        logic prev_lt;
        any_eq   = 1'b0;
        at_pos   = '0;
        rd_hit   = 1'b0;
        rd_value = '0;
        prev_lt  = 1'b1;
        for (int i = 0; i < CAPACITY; i++) begin
            // lt bits form a thermometer, so the edge is one-hot
            if (prev_lt && !stat[i].lt) begin
                at_pos = at_pos | PW'(i);
            end
            if (stat[i].eq) begin
                any_eq = 1'b1;
            end
            if (stat[i].sel && stat[i].valid) begin
                rd_hit   = 1'b1;
                rd_value = rd_value | value[i];
            end
            prev_lt = stat[i].lt;
        end
        full = stat[CAPACITY-1].valid;
    end

endmodule

`default_nettype wire

// ----- rtl/sorted_unique_set_builder.sv -----
// ----------------------------------------------------------------------------
// sorted_unique_set_builder
// Ascending table of distinct 32-bit values built from a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_tuser carries the request kind (insert, find, read), s_tdata the key
//   and the read index. Each request yields one result on m_tdata: hit,
//   position, entry value, entry count after the request and a dropped flag
//   for an insert of a new value into a full table.
//   A request is held in one input register and resolved when the result
//   register is free or m_tready is high: every cell compares its value with
//   the key at once, and on an insert the cells at and above the insert
//   point shift up by one while the slot at the insert point takes the key.
//   The result is registered and drives m_tvalid from the result register.
//   Throughput is one request per cycle while m_tready is high, set by the
//   single compare-and-shift pass over the cell row that each request needs.
//   When m_tready is low the result stays on m_tdata and one more request is
//   held in the input register; s_tready then drops until the result is taken.
//   After reset the table is empty (all cell valid bits clear, count zero)
//   and requests are taken at once.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_set_builder
    import sus_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // key_value[31:0], read_index[39:32]
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata    // hit[0], position[8:1], entry_value[40:9],
                                        // entry_count[49:41], dropped[50], zero[55:51]
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW    = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int OW    = (CW > CNT_O_W) ? CW : CNT_O_W;

    // request register
    logic              busy_reg;
    logic              busy_next;
    logic [1:0]        req_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [RIDX_W-1:0] ridx_reg;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              hit_reg;
    logic              hit_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [KEY_W-1:0]  val_reg;
    logic [KEY_W-1:0]  val_next;
    logic [CNT_O_W-1:0] cnt_out_reg;
    logic [CNT_O_W-1:0] cnt_out_next;
    logic              drop_reg;
    logic              drop_next;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [OW-1:0]     count_wide;

    logic              s_fire;
    logic              resolve;
    logic              ins_en;

    cell_stat_t        cell_stat  [CAPACITY];
    logic [KEY_W-1:0]  cell_value [CAPACITY];

    logic              any_eq;
    logic              full;
    logic [PW-1:0]     at_pos;
    logic              rd_hit;
    logic [KEY_W-1:0]  rd_value;

    assign resolve  = busy_reg && (!out_valid_reg || m_tready);
    assign s_tready = !busy_reg || resolve;
    assign s_fire   = s_tvalid && s_tready;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_head
            sus_cell #(
                .CELL_INDEX (i)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .key        (key_reg),
                .read_index (ridx_reg),
                .ins_en     (ins_en),
                .left_lt    (1'b1),
                .left_valid (1'b1),
                .left_value (key_reg),
                .value      (cell_value[i]),
                .stat       (cell_stat[i])
            );
        end else begin : g_body
            sus_cell #(
                .CELL_INDEX (i)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .key        (key_reg),
                .read_index (ridx_reg),
                .ins_en     (ins_en),
                .left_lt    (cell_stat[i-1].lt),
                .left_valid (cell_stat[i-1].valid),
                .left_value (cell_value[i-1]),
                .value      (cell_value[i]),
                .stat       (cell_stat[i])
            );
        end
    end

    sus_reduce #(
        .CAPACITY (CAPACITY),
        .PW       (PW)
    ) u_reduce (
        .stat     (cell_stat),
        .value    (cell_value),
        .any_eq   (any_eq),
        .full     (full),
        .at_pos   (at_pos),
        .rd_hit   (rd_hit),
        .rd_value (rd_value)
    );

    always_comb begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        drop_next      = drop_reg;
        count_next     = count_reg;
        ins_en         = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (resolve) begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            hit_next       = 1'b0;
            pos_next       = '0;
            val_next       = '0;
            drop_next      = 1'b0;
            unique case (req_reg)
                REQ_INSERT: begin
                    if (any_eq) begin
                        hit_next = 1'b1;
                        pos_next = at_pos[POS_W-1:0];
                    end else if (full) begin
                        drop_next = 1'b1;
                    end else begin
                        ins_en     = 1'b1;
                        pos_next   = at_pos[POS_W-1:0];
                        count_next = count_reg + CW'(1);
                    end
                end
                REQ_FIND: begin
                    if (any_eq) begin
                        hit_next = 1'b1;
                        pos_next = at_pos[POS_W-1:0];
                    end
                end
                REQ_READ: begin
                    hit_next = rd_hit;
                    val_next = rd_value;
                end
                default: begin
                end
            endcase
        end

        if (s_fire) begin
            busy_next = 1'b1;
        end

        count_wide   = OW'(count_next);
        cnt_out_next = resolve ? count_wide[CNT_O_W-1:0] : cnt_out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg  <= s_tuser;
            key_reg  <= s_tdata[KEY_W-1:0];
            ridx_reg <= s_tdata[KEY_W +: RIDX_W];
        end
        hit_reg     <= hit_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        cnt_out_reg <= cnt_out_next;
        drop_reg    <= drop_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, drop_reg, cnt_out_reg, val_reg, pos_reg, hit_reg};

endmodule

`default_nettype wire

// ----- rtl/sus_checker.sv -----
// ----------------------------------------------------------------------------
// sus_checker
// Port-level checks for the sorted unique set builder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_checker #(
    parameter int CAPACITY = 256
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);

    localparam logic [8:0] FULL_CNT = 9'(CAPACITY % 512);

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a request that meets m_tready high in the next cycle shows up after that
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("request result missing");

    // a dropped insert reports a full table and no match
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[50] |->
            !m_tdata[0] && (m_tdata[8:1] == 8'd0) && (m_tdata[49:41] == FULL_CNT))
        else $error("bad dropped result");

    // only read results carry an entry value, and they carry no position
    a_read_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[40:9] != 32'd0) |-> m_tdata[0] && (m_tdata[8:1] == 8'd0)
            && !m_tdata[50])
        else $error("entry value on a non-read result");

endmodule

bind sorted_unique_set_builder sus_checker #(
    .CAPACITY (CAPACITY)
) u_sus_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
